// ----- rtl/sbfr_pkg.sv -----
package sbfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 4096;
    localparam int POS_W    = 13;
    localparam int REQ_W    = 4;
    localparam int NBITS_W  = 6;
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int LEFT_W   = 4;
    localparam int RECT_N_W = 5;
    localparam int VAR_MAX  = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 4'd0,
        REQ_SEEK   = 4'd1,
        REQ_SKIP   = 4'd2,
        REQ_UB     = 4'd3,
        REQ_SB     = 4'd4,
        REQ_U8     = 4'd5,
        REQ_U16    = 4'd6,
        REQ_U32    = 4'd7,
        REQ_VARINT = 4'd8,
        REQ_U30    = 4'd9,
        REQ_RECT   = 4'd10,
        REQ_ALIGN  = 4'd11
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_FILL,
        S_BIT,
        S_BYTE,
        S_VCHK,
        S_VBYTE,
        S_RHDR,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/sbfr_req_if.sv -----
interface sbfr_req_if
    import sbfr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [REQ_W-1:0]      req_type;
    logic [NBITS_W-1:0]    num_bits;
    logic [POS_W-1:0]      position;
    logic [POS_W-1:0]      skip_count;
    logic [BYTE_W-1:0]     load_value;

    modport source (output valid, req_type, num_bits, position, skip_count, load_value,
                    input ready);
    modport sink   (input valid, req_type, num_bits, position, skip_count, load_value,
                    output ready);
endinterface

// ----- rtl/sbfr_res_if.sv -----
interface sbfr_res_if
    import sbfr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [VALUE_W-1:0]    value;
    logic                  status;
    logic                  last;

    modport source (output valid, value, status, last, input ready);
    modport sink   (input valid, value, status, last, output ready);
endinterface

// ----- rtl/swf_bitstream_field_reader.sv -----
// Load, seek, skip, align, unknown requests and range errors seen at decode go from decode
// straight to the result register; ub/sb, u8/u16/u32, varint/u30 and rect fetch their bytes
// first, and a varint or rect range error can also be found while reading. A held result
// stalls the block until the sink takes it.
// One transaction at a time: the next is accepted the cycle after the result register loads.
// Reset (synchronous) clears position, bit cache, buffer length and control; the store is not.
module swf_bitstream_field_reader
    import sbfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sbfr_req_if.sink         i_req,
    sbfr_res_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic [POS_W-1:0] i_cfg_data
);

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int DWB = $clog2(BUFFER_DEPTH + 1);
    localparam int SW  = (DWB > POS_W + 1) ? DWB + 1 : POS_W + 2;

    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    t_state               r_state, n_state;
    t_req                 r_req;
    logic [NBITS_W-1:0]   r_nb;
    logic [POS_W-1:0]     r_pos, r_cnt;
    logic [BYTE_W-1:0]    r_lv;
    logic [POS_W-1:0]     r_buf_len;
    logic [POS_W-1:0]     r_rp, n_rp;
    logic [BYTE_W-1:0]    r_cache, n_cache;
    logic [LEFT_W-1:0]    r_left, n_left;
    logic [VALUE_W-1:0]   r_acc, n_acc;
    logic [NBITS_W-1:0]   r_bits, n_bits;
    logic                 r_first, n_first;
    logic [2:0]           r_idx, n_idx;
    logic [POS_W-1:0]     r_ptr, n_ptr;
    logic                 r_err, n_err;
    logic [1:0]           r_fld, n_fld;
    logic [RECT_N_W-1:0]  r_rn, n_rn;
    logic                 r_hdr, n_hdr;
    logic                 r_ov, n_ov;
    logic [VALUE_W-1:0]   r_o_value, n_o_value;
    logic                 r_o_status, n_o_status;
    logic                 r_o_last, n_o_last;

    logic                 w_we;
    logic [AW-1:0]        w_raddr;
    logic [SW-1:0]        w_size;
    logic [SW-1:0]        w_rp_x;
    logic [NBITS_W:0]     w_need;
    logic [2:0]           w_len;
    logic                 w_bit;
    logic                 w_signed;
    logic [RECT_N_W-1:0]  w_n;
    logic [VALUE_W-1:0]   w_vpart;
    logic                 w_out_free;

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_res.valid  = r_ov;
    assign o_res.value  = r_o_value;
    assign o_res.status = r_o_status;
    assign o_res.last   = r_o_last;

    assign w_size = (SW'(r_buf_len) < SW'(BUFFER_DEPTH)) ? SW'(r_buf_len) : SW'(BUFFER_DEPTH);
    assign w_rp_x = SW'(r_rp);
    assign w_raddr = (r_req == REQ_VARINT || r_req == REQ_U30) ? AW'(r_ptr) : AW'(r_rp);
    assign w_out_free = !r_ov || o_res.ready;
    assign w_signed = (r_req != REQ_UB);
    assign w_bit = r_cache[3'(r_left - 4'd1)];
    assign w_n = r_rdata[BYTE_W-1 -: RECT_N_W];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[AW'(r_pos)] <= r_lv;
        end
        r_rdata <= mem[w_raddr];
    end

    always_comb begin
        w_need = '0;
        if (r_nb > NBITS_W'(r_left)) begin
            w_need = ((NBITS_W+1)'(r_nb - NBITS_W'(r_left)) + (NBITS_W+1)'(7)) >> 3;
        end
        unique case (r_req)
            REQ_U8:  w_len = 3'd1;
            REQ_U16: w_len = 3'd2;
            default: w_len = 3'd4;
        endcase
        unique case (r_idx)
            3'd0:    w_vpart = VALUE_W'(r_rdata[6:0]);
            3'd1:    w_vpart = VALUE_W'(r_rdata[6:0]) << 7;
            3'd2:    w_vpart = VALUE_W'(r_rdata[6:0]) << 14;
            3'd3:    w_vpart = VALUE_W'(r_rdata[6:0]) << 21;
            default: w_vpart = VALUE_W'(r_rdata[6:0]) << 28;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_rp       = r_rp;
        n_cache    = r_cache;
        n_left     = r_left;
        n_acc      = r_acc;
        n_bits     = r_bits;
        n_first    = r_first;
        n_idx      = r_idx;
        n_ptr      = r_ptr;
        n_err      = r_err;
        n_fld      = r_fld;
        n_rn       = r_rn;
        n_hdr      = r_hdr;
        n_ov       = r_ov && !o_res.ready;
        n_o_value  = r_o_value;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        w_we       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_acc   = '0;
                n_err   = 1'b0;
                n_state = S_EMIT;
                priority case (r_req)
                    REQ_LOAD: begin
                        if (SW'(r_pos) >= SW'(BUFFER_DEPTH)) begin
                            n_err = 1'b1;
                        end else begin
                            w_we = 1'b1;
                        end
                    end
                    REQ_SEEK: begin
                        if (SW'(r_pos) > w_size) begin
                            n_err = 1'b1;
                        end else begin
                            n_rp    = r_pos;
                            n_cache = '0;
                            n_left  = '0;
                        end
                    end
                    REQ_SKIP: begin
                        if (w_rp_x + SW'(r_cnt) > w_size) begin
                            n_err = 1'b1;
                        end else begin
                            n_rp    = r_rp + r_cnt;
                            n_cache = '0;
                            n_left  = '0;
                        end
                    end
                    REQ_UB, REQ_SB: begin
                        if (w_rp_x + SW'(w_need) > w_size) begin
                            n_err = 1'b1;
                        end else begin
                            n_bits  = r_nb;
                            n_first = 1'b1;
                            n_state = S_BIT;
                        end
                    end
                    REQ_U8, REQ_U16, REQ_U32: begin
                        if (w_rp_x + SW'(w_len) > w_size) begin
                            n_err = 1'b1;
                        end else begin
                            n_cache = '0;
                            n_left  = '0;
                            n_idx   = '0;
                            n_state = S_FETCH;
                        end
                    end
                    REQ_VARINT, REQ_U30: begin
                        n_ptr   = r_rp;
                        n_idx   = '0;
                        n_state = S_VCHK;
                    end
                    REQ_RECT: begin
                        if (w_rp_x + SW'(1) > w_size) begin
                            n_err = 1'b1;
                        end else begin
                            n_hdr   = 1'b1;
                            n_state = S_FETCH;
                        end
                    end
                    REQ_ALIGN: begin
                        n_cache = '0;
                        n_left  = '0;
                    end
                    default: ;
                endcase
            end
            S_FETCH: begin
                priority case (r_req)
                    REQ_U8, REQ_U16, REQ_U32: n_state = S_BYTE;
                    REQ_VARINT, REQ_U30:      n_state = S_VBYTE;
                    REQ_RECT:                 n_state = r_hdr ? S_RHDR : S_FILL;
                    default:                  n_state = S_FILL;
                endcase
            end
            S_FILL: begin
                n_cache = r_rdata;
                n_left  = LEFT_W'(BYTE_W);
                n_rp    = r_rp + POS_W'(1);
                n_state = S_BIT;
            end
            S_BIT: begin
                if (r_bits == '0) begin
                    n_state = S_EMIT;
                end else if (r_left == '0) begin
                    n_state = S_FETCH;
                end else begin
                    // the first bit seeds the sign fill, later bits shift it out
                    if (r_first) begin
                        n_acc = {{(VALUE_W-1){w_bit & w_signed}}, w_bit};
                    end else begin
                        n_acc = {r_acc[VALUE_W-2:0], w_bit};
                    end
                    n_first = 1'b0;
                    n_left  = r_left - LEFT_W'(1);
                    n_bits  = r_bits - NBITS_W'(1);
                end
            end
            S_BYTE: begin
                n_acc[8*r_idx[1:0] +: 8] = r_rdata;
                n_rp  = r_rp + POS_W'(1);
                n_idx = r_idx + 3'd1;
                if (r_idx == w_len - 3'd1) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_VCHK: begin
                if (SW'(r_ptr) + SW'(1) > w_size) begin
                    n_acc   = '0;
                    n_err   = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_VBYTE: begin
                n_acc = r_acc | w_vpart;
                n_ptr = r_ptr + POS_W'(1);
                n_idx = r_idx + 3'd1;
                if (!r_rdata[7] || r_idx == 3'(VAR_MAX - 1)) begin
                    n_rp    = r_ptr + POS_W'(1);
                    n_cache = '0;
                    n_left  = '0;
                    if (r_req == REQ_U30) begin
                        n_acc[VALUE_W-1 -: 2] = 2'b00;
                    end
                    n_state = S_EMIT;
                end else begin
                    n_state = S_VCHK;
                end
            end
            S_RHDR: begin
                n_hdr = 1'b0;
                if (w_rp_x + SW'(1) + SW'((RECT_N_W+1)'(w_n) + 1'b1 >> 1) > w_size) begin
                    n_acc   = '0;
                    n_err   = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_cache = r_rdata;
                    n_left  = LEFT_W'(BYTE_W - RECT_N_W);
                    n_rp    = r_rp + POS_W'(1);
                    n_rn    = w_n;
                    n_fld   = '0;
                    n_bits  = NBITS_W'(w_n);
                    n_first = 1'b1;
                    n_acc   = '0;
                    n_state = S_BIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_ov       = 1'b1;
                    n_o_value  = r_err ? '0 : r_acc;
                    n_o_status = r_err;
                    n_o_last   = !(r_req == REQ_RECT && !r_err && r_fld != 2'd3);
                    if (r_req == REQ_RECT && !r_err && r_fld != 2'd3) begin
                        n_fld   = r_fld + 2'd1;
                        n_bits  = NBITS_W'(r_rn);
                        n_first = 1'b1;
                        n_acc   = '0;
                        n_state = S_BIT;
                    end else begin
                        if (r_req == REQ_RECT && !r_err) begin
                            n_cache = '0;
                            n_left  = '0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_buf_len <= '0;
            r_rp      <= '0;
            r_cache   <= '0;
            r_left    <= '0;
            r_ov      <= 1'b0;
            r_hdr     <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_cache <= n_cache;
            r_left  <= n_left;
            r_ov    <= n_ov;
            r_hdr   <= n_hdr;
            r_err   <= n_err;
            if (i_cfg_we) begin
                r_buf_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_req <= t_req'(i_req.req_type);
            r_nb  <= (i_req.num_bits > NBITS_W'(VALUE_W)) ? NBITS_W'(VALUE_W)
                                                          : i_req.num_bits;
            r_pos <= i_req.position;
            r_cnt <= i_req.skip_count;
            r_lv  <= i_req.load_value;
        end
        r_acc      <= n_acc;
        r_bits     <= n_bits;
        r_first    <= n_first;
        r_idx      <= n_idx;
        r_ptr      <= n_ptr;
        r_fld      <= n_fld;
        r_rn       <= n_rn;
        r_o_value  <= n_o_value;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import sbfr_pkg::*;

    typedef struct {
        logic [REQ_W-1:0]   req;
        logic [NBITS_W-1:0] nb;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   cnt;
        logic [BYTE_W-1:0]  lv;
    } t_field_req;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               status;
        logic               last;
    } t_field_res;

    typedef struct {
        t_field_req         it;
        bit                 typed;
        logic [VALUE_W-1:0] ev;
        logic               es;
    } t_stim_row;

    localparam int DEPTH   = 4096;
    localparam int FILL_N  = 64;
    localparam int PHASE_N = 90;
    localparam int HOLD_N  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [POS_W-1:0] i_cfg_data;

    sbfr_req_if req_ch();
    sbfr_res_if res_ch();

    swf_bitstream_field_reader u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [7:0]   shadow_store [DEPTH];
    int unsigned  shadow_len;
    int unsigned  shadow_pos;
    int unsigned  shadow_cache;
    int unsigned  shadow_left;

    t_field_res   pending_q[$];
    int           errors = 0;
    int           mismatches = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           src_idle_pct = 0;
    int           snk_idle_pct = 0;
    int           hold_reqs = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    function automatic int unsigned size_now();
        return shadow_len < DEPTH ? shadow_len : DEPTH;
    endfunction

    function automatic int unsigned byte_at(int unsigned a);
        return a < DEPTH ? 32'(shadow_store[a]) : 0;
    endfunction

    function automatic bit fits(int unsigned n);
        int unsigned need;
        need = 0;
        if (n > shadow_left) need = (n - shadow_left + 7) / 8;
        return shadow_pos + need <= size_now();
    endfunction

    function automatic int unsigned pull_bits(int unsigned n);
        int unsigned r, tk, sh;
        r = 0;
        while (n > 0) begin
            if (shadow_left == 0) begin
                shadow_cache = byte_at(shadow_pos);
                shadow_pos = (shadow_pos + 1) & 32'h1FFF;
                shadow_left = 8;
            end
            tk = n < shadow_left ? n : shadow_left;
            sh = shadow_left - tk;
            r = (r << tk) | ((shadow_cache >> sh) & ((1 << tk) - 1));
            n -= tk;
            shadow_left -= tk;
        end
        return r;
    endfunction

    function automatic int unsigned sext(int unsigned v, int unsigned n);
        if (n > 0 && n < 32 && v[n-1]) v |= ~((32'd1 << n) - 1);
        return v;
    endfunction

    function automatic t_field_res mk(int unsigned v, bit s, bit l);
        t_field_res r;
        r.value = v;
        r.status = s;
        r.last = l;
        return r;
    endfunction

    // compute the results of one request and advance the shadow state
    function automatic void predict_fields(t_field_req it, ref t_field_res outs[$]);
        int unsigned nb, sz, v, len, p, sh, b, n, sp, sc, sl;
        nb = it.nb > 32 ? 32 : 32'(it.nb);
        sz = size_now();
        v = 0;
        outs.delete();
        case (it.req)
            REQ_LOAD: begin
                if (it.pos >= DEPTH) begin outs = {outs, mk(0, 1'b1, 1'b1)}; return; end
                shadow_store[it.pos] = it.lv;
            end
            REQ_SEEK: begin
                if (it.pos > sz) begin outs = {outs, mk(0, 1'b1, 1'b1)}; return; end
                shadow_pos = 32'(it.pos);
                shadow_cache = 0;
                shadow_left = 0;
            end
            REQ_SKIP: begin
                if (shadow_pos + it.cnt > sz) begin
                    outs = {outs, mk(0, 1'b1, 1'b1)};
                    return;
                end
                shadow_pos = (shadow_pos + it.cnt) & 32'h1FFF;
                shadow_cache = 0;
                shadow_left = 0;
            end
            REQ_UB, REQ_SB: begin
                if (!fits(nb)) begin outs = {outs, mk(0, 1'b1, 1'b1)}; return; end
                v = pull_bits(nb);
                if (it.req == REQ_SB) v = sext(v, nb);
            end
            REQ_U8, REQ_U16, REQ_U32: begin
                len = it.req == REQ_U8 ? 1 : (it.req == REQ_U16 ? 2 : 4);
                if (shadow_pos + len > sz) begin outs = {outs, mk(0, 1'b1, 1'b1)}; return; end
                shadow_cache = 0;
                shadow_left = 0;
                for (int i = 0; i < len; i++) v |= byte_at(shadow_pos + i) << (8 * i);
                shadow_pos = (shadow_pos + len) & 32'h1FFF;
            end
            REQ_VARINT, REQ_U30: begin
                p = shadow_pos;
                sh = 0;
                while (sh < 35) begin
                    if (p + 1 > sz) begin outs = {outs, mk(0, 1'b1, 1'b1)}; return; end
                    b = byte_at(p);
                    p++;
                    v |= (b & 32'h7F) << sh;
                    if ((b & 32'h80) == 0) break;
                    sh += 7;
                end
                shadow_pos = p & 32'h1FFF;
                shadow_cache = 0;
                shadow_left = 0;
                if (it.req == REQ_U30) v &= 32'h3FFF_FFFF;
            end
            REQ_RECT: begin
                sp = shadow_pos; sc = shadow_cache; sl = shadow_left;
                shadow_cache = 0;
                shadow_left = 0;
                if (!fits(5)) begin
                    shadow_pos = sp; shadow_cache = sc; shadow_left = sl;
                    outs = {outs, mk(0, 1'b1, 1'b1)};
                    return;
                end
                n = pull_bits(5);
                if (!fits(4 * n)) begin
                    shadow_pos = sp; shadow_cache = sc; shadow_left = sl;
                    outs = {outs, mk(0, 1'b1, 1'b1)};
                    return;
                end
                for (int i = 0; i < 4; i++)
                    outs = {outs, mk(sext(pull_bits(n), n), 1'b0, i == 3)};
                shadow_cache = 0;
                shadow_left = 0;
                return;
            end
            REQ_ALIGN: begin
                shadow_cache = 0;
                shadow_left = 0;
            end
            default: ;
        endcase
        outs = {outs, mk(v, 1'b0, 1'b1)};
    endfunction

    // call at a rising edge; returns at the edge where the transaction is accepted
    task automatic send(t_field_req it, bit typed = 1'b0, logic [31:0] ev = '0,
                        logic es = 1'b0);
        t_field_res outs[$];
        if ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= it.req;
        req_ch.num_bits   <= it.nb;
        req_ch.position   <= it.pos;
        req_ch.skip_count <= it.cnt;
        req_ch.load_value <= it.lv;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
        predict_fields(it, outs);
        if (typed) pending_q = {pending_q, mk(ev, es, 1'b1)};
        else foreach (outs[i]) pending_q = {pending_q, outs[i]};
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_length(int unsigned len);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len[POS_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_len = len & 32'h1FFF;
        @(posedge i_clk);
    endtask

    function automatic t_field_req mkreq(logic [3:0] r, int nb = 0, int pos = 0, int cnt = 0,
                                         int lv = 0);
        t_field_req it;
        it.req = r;
        it.nb  = NBITS_W'(nb);
        it.pos = POS_W'(pos);
        it.cnt = POS_W'(cnt);
        it.lv  = BYTE_W'(lv);
        return it;
    endfunction

    // mostly well-formed reads within the written region, some noise
    function automatic t_field_req rand_req();
        t_field_req it;
        int r;
        it.req = REQ_W'($urandom);
        it.nb  = NBITS_W'($urandom);
        it.pos = POS_W'($urandom);
        it.cnt = POS_W'($urandom);
        it.lv  = BYTE_W'($urandom);
        r = $urandom_range(99);
        if (r < 12) begin
            it.req = REQ_LOAD;
            if ($urandom_range(4) != 0) it.pos = POS_W'($urandom_range(0, FILL_N - 1));
        end else if (r < 27) begin
            it.req = REQ_SEEK;
            if ($urandom_range(9) != 0) it.pos = POS_W'($urandom_range(0, shadow_len + 2));
        end else if (r < 32) begin
            it.req = REQ_SKIP;
            if ($urandom_range(9) != 0) it.cnt = POS_W'($urandom_range(0, 8));
        end else if (r < 50) begin
            it.req = $urandom_range(0, 1) ? REQ_UB : REQ_SB;
            if ($urandom_range(9) != 0) it.nb = NBITS_W'($urandom_range(0, 34));
        end else if (r < 58) it.req = REQ_U8;
        else if (r < 64) it.req = REQ_U16;
        else if (r < 70) it.req = REQ_U32;
        else if (r < 77) it.req = REQ_VARINT;
        else if (r < 83) it.req = REQ_U30;
        else if (r < 92) it.req = REQ_RECT;
        else if (r < 97) it.req = REQ_ALIGN;
        else it.req = REQ_W'($urandom_range(12, 15));
        return it;
    endfunction

    // sink side: check, then decide ready for the next cycle
    always @(posedge i_clk) begin
        t_field_res e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result value=%h status=%b last=%b",
                             res_ch.value, res_ch.status, res_ch.last);
            end else begin
                e = pending_q.pop_front();
                if (res_ch.value !== e.value || res_ch.status !== e.status ||
                    res_ch.last !== e.last) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch exp value=%h status=%b last=%b got %h %b %b",
                                 e.value, e.status, e.last,
                                 res_ch.value, res_ch.status, res_ch.last);
                end
            end
        end
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_N;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_stim_row table_a[$];
        t_stim_row table_b[$];
        t_stim_row row;

        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= '0;
        req_ch.num_bits   <= '0;
        req_ch.position   <= '0;
        req_ch.skip_count <= '0;
        req_ch.load_value <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_rst_n    <= 1'b0;
        shadow_len = 0; shadow_pos = 0; shadow_cache = 0; shadow_left = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty buffer: every read fails except zero-width bit reads, moves succeed only to zero
        row.typed = 1'b1; row.ev = '0;
        row.it = mkreq(REQ_U8);                    row.es = 1'b1; table_a = {table_a, row};
        row.it = mkreq(REQ_SEEK, 0, 0);            row.es = 1'b0; table_a = {table_a, row};
        row.it = mkreq(REQ_SEEK, 0, 1);            row.es = 1'b1; table_a = {table_a, row};
        row.it = mkreq(REQ_UB, 0);                 row.es = 1'b0; table_a = {table_a, row};
        row.it = mkreq(REQ_SB, 0);                 row.es = 1'b0; table_a = {table_a, row};
        row.it = mkreq(REQ_LOAD, 0, 4096, 0, 255); row.es = 1'b1; table_a = {table_a, row};
        row.it = mkreq(REQ_LOAD, 0, 8191, 0, 1);   row.es = 1'b1; table_a = {table_a, row};
        row.it = mkreq(4'd15, 63, 8191, 8191, 255); row.es = 1'b0; table_a = {table_a, row};
        row.it = mkreq(REQ_ALIGN);                 row.es = 1'b0; table_a = {table_a, row};
        row.it = mkreq(REQ_SKIP, 0, 0, 0);         row.es = 1'b0; table_a = {table_a, row};
        row.it = mkreq(REQ_SKIP, 0, 0, 8191);      row.es = 1'b1; table_a = {table_a, row};
        row.it = mkreq(REQ_VARINT);                row.es = 1'b1; table_a = {table_a, row};
        row.it = mkreq(REQ_RECT);                  row.es = 1'b1; table_a = {table_a, row};
        row.it = mkreq(REQ_UB, 32);                row.es = 1'b1; table_a = {table_a, row};
        row.it = mkreq(REQ_U32);                   row.es = 1'b1; table_a = {table_a, row};

        write_length(0);
        foreach (table_a[i]) send(table_a[i].it, 1'b1, table_a[i].ev, table_a[i].es);

        // fill the low store: long varint, rect width zero at 10, width 31 at 11
        for (int a = 0; a < FILL_N; a++) begin
            int v;
            v = $urandom_range(0, 255);
            if (a < 4) v = 8'hFF;
            else if (a == 4) v = 8'h0F;
            else if (a == 10) v = 8'h07;
            else if (a == 11) v = 8'hF8;
            send(mkreq(REQ_LOAD, 0, a, 0, v), 1'b1, '0, 1'b0);
        end
        write_length(FILL_N);

        row.typed = 1'b0;
        row.it = mkreq(REQ_VARINT);        table_b = {table_b, row};
        row.it = mkreq(REQ_SEEK, 0, 0);    table_b = {table_b, row};
        row.it = mkreq(REQ_U30);           table_b = {table_b, row};
        row.it = mkreq(REQ_SEEK, 0, 0);    table_b = {table_b, row};
        row.it = mkreq(REQ_UB, 32);        table_b = {table_b, row};
        row.it = mkreq(REQ_SB, 32);        table_b = {table_b, row};
        row.it = mkreq(REQ_UB, 63);        table_b = {table_b, row};
        row.it = mkreq(REQ_SB, 3);         table_b = {table_b, row};
        row.it = mkreq(REQ_ALIGN);         table_b = {table_b, row};
        row.it = mkreq(REQ_U16);           table_b = {table_b, row};
        row.it = mkreq(REQ_SEEK, 0, 10);   table_b = {table_b, row};
        row.it = mkreq(REQ_RECT);          table_b = {table_b, row};
        row.it = mkreq(REQ_SEEK, 0, 11);   table_b = {table_b, row};
        row.it = mkreq(REQ_RECT);          table_b = {table_b, row};
        row.it = mkreq(REQ_SEEK, 0, 64);   table_b = {table_b, row};
        row.it = mkreq(REQ_U8);            table_b = {table_b, row};
        row.it = mkreq(REQ_SKIP, 0, 0, 0); table_b = {table_b, row};
        foreach (table_b[i]) send(table_b[i].it);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
                1: begin src_idle_pct = 57; snk_idle_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_idle_pct = 57; end
                default: begin src_idle_pct = 17; snk_idle_pct = 17; end
            endcase
            write_length(ph == 1 ? $urandom_range(1, FILL_N) : FILL_N);
            send(mkreq(REQ_SEEK, 0, 0));
            for (int k = 0; k < PHASE_N; k++) begin
                // stall the sink for a long stretch while requests keep coming
                if (ph == 0 && k == 30) hold_reqs++;
                if (ph == 3 && k == 50) drain();
                send(rand_req());
            end
        end

        // largest length value; the store size caps it, and reads that succeed stay inside the written bytes
        src_idle_pct = 0; snk_idle_pct = 0;
        write_length(8191);
        send(mkreq(REQ_SEEK, 0, 4096));
        send(mkreq(REQ_U8));
        send(mkreq(REQ_SKIP, 0, 0, 1));
        send(mkreq(REQ_SEEK, 0, 4097));
        send(mkreq(REQ_SEEK, 0, 5));
        send(mkreq(REQ_UB, 13));
        send(mkreq(REQ_U16));

        drain();
        $display("ran %0d requests over lengths 0 to 8191, %0d results checked",
                 items_sent, results_seen);
        $display("all request kinds, out-of-range cases and four idle mixes exercised");
        if (errors == 0 && pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
